// ----- rtl/til_pkg.sv -----
// Shared constants and types for the triangle interior lattice point counter.
package til_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned RES_W           = 31;
  localparam logic [RES_W-1:0] RESULT_MAX = {RES_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD1,
    ST_GCD2,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

// ----- rtl/til_if.sv -----
// Valid/ready channel interfaces for triangle input and count output.
interface til_in_if #(
  parameter int unsigned COORD_WIDTH = til_pkg::COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] apex_x;
  logic [COORD_WIDTH-1:0] height;
  logic [COORD_WIDTH-1:0] base_len;

  modport source(output valid, apex_x, height, base_len, input ready);
  modport sink(input valid, apex_x, height, base_len, output ready);
endinterface

interface til_out_if;
  logic                          valid;
  logic                          ready;
  logic [til_pkg::RES_W-1:0]     interior_points;

  modport source(output valid, interior_points, input ready);
  modport sink(input valid, interior_points, output ready);
endinterface

// ----- rtl/til_gcd_step.sv -----
// One step of binary gcd: halve, halve both, or subtract the smaller operand.
module til_gcd_step #(
  parameter int unsigned COORD_WIDTH = til_pkg::COORD_WIDTH_DEF,
  parameter int unsigned KW          = $clog2(COORD_WIDTH + 1)
) (
  input  logic [COORD_WIDTH-1:0] a,
  input  logic [COORD_WIDTH-1:0] b,
  input  logic [KW-1:0]          k,
  output logic [COORD_WIDTH-1:0] a_out,
  output logic [COORD_WIDTH-1:0] b_out,
  output logic [KW-1:0]          k_out,
  output logic                   done
);

  assign done = (a == '0);

  always_comb begin
    a_out = a;
    b_out = b;
    k_out = k;
    priority if (done) begin
      // hold: gcd is b << k
    end else if (!a[0] && !b[0]) begin
      a_out = a >> 1;
      b_out = b >> 1;
      k_out = KW'(k + 1'b1);
    end else if (!a[0]) begin
      a_out = a >> 1;
    end else if (!b[0]) begin
      b_out = b >> 1;
    end else if (a >= b) begin
      a_out = a - b;
    end else begin
      b_out = b - a;
    end
  end

endmodule

// ----- rtl/triangle_interior_lattice_count.sv -----
// Counts lattice points strictly inside the triangle (0,0), (apex_x,height),
// (base_len,0) by Pick's theorem. One transaction at a time: the block accepts
// a triangle in ST_IDLE, then runs two gcds through a single shared binary-gcd
// step unit (one halve or subtract per cycle, data dependent; each gcd ends when
// the unit flags done), does the base*height multiply in ST_MUL and forms the
// count in ST_FIN. A zero height or base skips straight to a count of 0.
// The result sits in an output register, so a new triangle is accepted while
// the previous count waits to be taken.
module triangle_interior_lattice_count #(
  parameter int unsigned COORD_WIDTH = til_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  til_in_if.sink    in_ch,
  til_out_if.source out_ch
);

  localparam int unsigned KW = $clog2(COORD_WIDTH + 1);
  localparam int unsigned PW = 2 * COORD_WIDTH;
  localparam int unsigned BW = COORD_WIDTH + 2;
  localparam int unsigned SW = (PW > til_pkg::RES_W) ? PW : til_pkg::RES_W;

  til_pkg::state_t state_r, state_nxt;

  logic [COORD_WIDTH-1:0]    h_r, h_nxt;
  logic [COORD_WIDTH-1:0]    bl_r, bl_nxt;
  logic [COORD_WIDTH-1:0]    dx_r, dx_nxt;
  logic [COORD_WIDTH-1:0]    a_r, a_nxt;
  logic [COORD_WIDTH-1:0]    b_r, b_nxt;
  logic [KW-1:0]             k_r, k_nxt;
  logic [COORD_WIDTH-1:0]    g1_r, g1_nxt;
  logic [COORD_WIDTH-1:0]    g2_r, g2_nxt;
  logic [PW-1:0]             prod_r, prod_nxt;
  logic                      zero_r, zero_nxt;
  logic [til_pkg::RES_W-1:0] res_r, res_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [COORD_WIDTH-1:0] step_a, step_b;
  logic [KW-1:0]          step_k;
  logic                   step_done;
  logic [COORD_WIDTH-1:0] gcd_val;

  logic [BW-1:0]          boundary;
  logic [PW-1:0]          half_area;
  logic [PW-1:0]          half_b;
  logic [PW-1:0]          diff;
  logic [SW-1:0]          diff_ext;
  logic [til_pkg::RES_W-1:0] count;

  til_gcd_step #(
    .COORD_WIDTH(COORD_WIDTH),
    .KW         (KW)
  ) u_gcd_step (
    .a    (a_r),
    .b    (b_r),
    .k    (k_r),
    .a_out(step_a),
    .b_out(step_b),
    .k_out(step_k),
    .done (step_done)
  );

  assign gcd_val = b_r << k_r;

  // Pick: I = floor(bl*h/2) + 1 - floor(B/2), clamped to [0, RESULT_MAX]
  assign boundary  = BW'(g1_r) + BW'(bl_r) + BW'(g2_r);
  assign half_area = (prod_r >> 1) + PW'(1);
  assign half_b    = PW'(boundary[BW-1:1]);
  assign diff      = (half_b >= half_area) ? '0 : (half_area - half_b);
  assign diff_ext  = SW'(diff);
  assign count     = (diff_ext > SW'(til_pkg::RESULT_MAX)) ? til_pkg::RESULT_MAX
                                                           : diff_ext[til_pkg::RES_W-1:0];

  assign in_ch.ready            = (state_r == til_pkg::ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.interior_points = res_r;

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    bl_nxt        = bl_r;
    dx_nxt        = dx_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    g1_nxt        = g1_r;
    g2_nxt        = g2_r;
    prod_nxt      = prod_r;
    zero_nxt      = zero_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      til_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          h_nxt    = in_ch.height;
          bl_nxt   = in_ch.base_len;
          dx_nxt   = (in_ch.apex_x >= in_ch.base_len) ? (in_ch.apex_x - in_ch.base_len)
                                                      : (in_ch.base_len - in_ch.apex_x);
          a_nxt    = in_ch.apex_x;
          b_nxt    = in_ch.height;
          k_nxt    = '0;
          zero_nxt = (in_ch.height == '0) || (in_ch.base_len == '0);
          // degenerate triangle: drop the gcd work
          state_nxt = zero_nxt ? til_pkg::ST_FIN : til_pkg::ST_GCD1;
        end
      end
      til_pkg::ST_GCD1: begin
        if (step_done) begin
          g1_nxt    = gcd_val;
          a_nxt     = dx_r;
          b_nxt     = h_r;
          k_nxt     = '0;
          state_nxt = til_pkg::ST_GCD2;
        end else begin
          a_nxt = step_a;
          b_nxt = step_b;
          k_nxt = step_k;
        end
      end
      til_pkg::ST_GCD2: begin
        if (step_done) begin
          g2_nxt    = gcd_val;
          state_nxt = til_pkg::ST_MUL;
        end else begin
          a_nxt = step_a;
          b_nxt = step_b;
          k_nxt = step_k;
        end
      end
      til_pkg::ST_MUL: begin
        prod_nxt  = PW'(bl_r) * PW'(h_r);
        state_nxt = til_pkg::ST_FIN;
      end
      til_pkg::ST_FIN: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ch.ready) begin
          res_nxt       = zero_r ? '0 : count;
          out_valid_nxt = 1'b1;
          state_nxt     = til_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = til_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= til_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    bl_r   <= bl_nxt;
    dx_r   <= dx_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    g1_r   <= g1_nxt;
    g2_r   <= g2_nxt;
    prod_r <= prod_nxt;
    zero_r <= zero_nxt;
    res_r  <= res_nxt;
  end

`ifndef ASSERT_OFF
  a_gcd_b_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == til_pkg::ST_GCD1 || state_r == til_pkg::ST_GCD2) |-> (b_r != '0))
    else $error("gcd operand b reached zero");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != til_pkg::ST_IDLE))
    else $error("accepted transaction did not start work");

  a_gcd1_to_gcd2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == til_pkg::ST_GCD1 && step_done) |=> (state_r == til_pkg::ST_GCD2))
    else $error("first gcd finished without starting the second");

  a_load_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == til_pkg::ST_FIN))
    else $error("result loaded outside the finish state");

  a_fin_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == til_pkg::ST_FIN && out_valid_r && !out_ch.ready) |=> $stable(res_r))
    else $error("pending result overwritten");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for triangle_interior_lattice_count: directed table, then random triangles.
module testbench;

  localparam int unsigned CW = til_pkg::COORD_WIDTH_DEF;
  localparam int N_ROWS = 21;
  localparam int N_RANDOM = 450;
  localparam int HOLD_OFF = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;

  typedef logic [CW-1:0] coord_t;
  typedef logic [til_pkg::RES_W-1:0] count_t;

  typedef struct {
    coord_t apex_x;
    coord_t height;
    coord_t base_len;
    bit     typed_in;
    count_t count;
  } triangle_row_t;

  logic clk;
  logic rst_n;

  til_in_if #(.COORD_WIDTH(CW)) in_ch ();
  til_out_if out_ch ();

  triangle_interior_lattice_count #(.COORD_WIDTH(CW)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  count_t expected_counts[$];
  int mismatches = 0;
  int results_taken = 0;
  int quiet_cycles = 0;
  bit burst_window = 0;  // neither side idles while set

  // Rows with typed_in set carry a count that follows directly from the formula.
  triangle_row_t directed_rows [N_ROWS] = '{
    '{16'd0,     16'd0,     16'd1,     1'b1, 31'd0},
    '{16'd5,     16'd0,     16'd7,     1'b1, 31'd0},
    '{16'd3,     16'd4,     16'd0,     1'b1, 31'd0},
    '{16'd0,     16'd0,     16'd0,     1'b1, 31'd0},
    '{16'hFFFF,  16'd0,     16'hFFFF,  1'b1, 31'd0},
    '{16'hFFFF,  16'hFFFF,  16'd0,     1'b1, 31'd0},
    '{16'd0,     16'd1,     16'd1,     1'b1, 31'd0},
    '{16'd0,     16'hFFFF,  16'hFFFF,  1'b1, 31'd2147319811},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 31'd0},
    '{16'hFFFF,  16'hFFFF,  16'd1,     1'b0, 31'd0},
    '{16'hFFFF,  16'd1,     16'hFFFF,  1'b0, 31'd0},
    '{16'd0,     16'hFFFF,  16'd1,     1'b0, 31'd0},
    '{16'd1,     16'hFFFF,  16'hFFFF,  1'b0, 31'd0},
    '{16'h8000,  16'hFFFF,  16'hFFFF,  1'b0, 31'd0},
    '{16'd4,     16'd3,     16'd8,     1'b0, 31'd0},
    '{16'd40000, 16'd30000, 16'd50000, 1'b0, 31'd0},
    '{16'd12,    16'd18,    16'd24,    1'b0, 31'd0},
    '{16'd2,     16'd2,     16'd2,     1'b0, 31'd0},
    '{16'd7,     16'd9,     16'd3,     1'b0, 31'd0},
    '{16'hFFFE,  16'h8000,  16'hFFFE,  1'b0, 31'd0},
    '{16'h5555,  16'hAAAA,  16'hAAAA,  1'b0, 31'd0}
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic longint unsigned common_divisor(longint unsigned a, longint unsigned b);
    longint unsigned r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  // Pick's theorem: I = A - B/2 + 1, with 2A = base * height.
  function automatic count_t count_interior_points(coord_t ax, coord_t h, coord_t bl);
    longint unsigned x, y, b, dx, border, half_area, pts;
    x = ax;
    y = h;
    b = bl;
    if (y == 0 || b == 0) return '0;
    dx = (x >= b) ? x - b : b - x;
    border = common_divisor(x, y) + b + common_divisor(dx, y);
    half_area = b * y / 2 + 1;
    pts = (border / 2 >= half_area) ? 0 : half_area - border / 2;
    if (pts > til_pkg::RESULT_MAX) pts = til_pkg::RESULT_MAX;
    return count_t'(pts);
  endfunction

  function automatic coord_t draw_extent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return coord_t'($urandom_range(1, 65535));
      4: return coord_t'($urandom_range(1, 15));
      5: return coord_t'(16'hFFFF - $urandom_range(0, 15));
      6: return coord_t'($urandom_range(1, 255) << $urandom_range(0, 8));
      7: return coord_t'(1 << $urandom_range(0, 15));
      default: return coord_t'($urandom_range(1, 4095));
    endcase
  endfunction

  task automatic offer_triangle(input coord_t ax, input coord_t h, input coord_t bl,
                                input bit typed_in, input count_t typed_count, input int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.apex_x <= ax;
    in_ch.height <= h;
    in_ch.base_len <= bl;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    expected_counts.push_back(typed_in ? typed_count : count_interior_points(ax, h, bl));
  endtask

  // Hold the input idle until every outstanding count has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (expected_counts.size() == 0);
    @(posedge clk);
  endtask

  initial begin : stimulus
    coord_t ax, h, bl;
    in_ch.valid <= 1'b0;
    in_ch.apex_x <= '0;
    in_ch.height <= '0;
    in_ch.base_len <= '0;
    out_ch.ready <= 1'b0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      offer_triangle(directed_rows[i].apex_x, directed_rows[i].height,
                     directed_rows[i].base_len, directed_rows[i].typed_in,
                     directed_rows[i].count, $urandom_range(0, 11));
    end
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      burst_window = (i >= 150 && i < 210);
      h = draw_extent();
      bl = draw_extent();
      case ($urandom_range(0, 7))
        0: ax = bl;
        1: ax = '0;
        2: ax = draw_extent();
        3: ax = h;
        default: ax = coord_t'($urandom_range(0, 65535));
      endcase
      // degenerate triangles now and then
      if ($urandom_range(0, 39) == 0) h = '0;
      else if ($urandom_range(0, 39) == 0) bl = '0;
      if (i == 300) drain_results();
      offer_triangle(ax, h, bl, 1'b0, '0, burst_window ? 0 : $urandom_range(0, 11));
    end
    in_ch.valid <= 1'b0;

    wait (expected_counts.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : count_sink
    int stall;
    count_t want;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (results_taken == 40) stall = HOLD_OFF;
      else if (burst_window) stall = 0;
      else stall = $urandom_range(0, 11);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      results_taken++;
      if (expected_counts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction: expected none, actual %0d",
                 $time, out_ch.interior_points);
      end else begin
        want = expected_counts.pop_front();
        if (out_ch.interior_points !== want) begin
          mismatches++;
          $display("%0t: interior_points mismatch: expected %0d, actual %0d",
                   $time, want, out_ch.interior_points);
        end
      end
    end
  end

  // End the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/til_pkg.sv
rtl/til_if.sv
rtl/til_gcd_step.sv
rtl/triangle_interior_lattice_count.sv
dv/testbench.sv
